// ----- rtl/sorted_group_distinct_count_top_macros.svh -----
// Assertion macros shared by the checker of the grouping block.
// Holds macro definitions only; no dependencies.
`ifndef SORTED_GROUP_DISTINCT_COUNT_TOP_MACROS_SVH
`define SORTED_GROUP_DISTINCT_COUNT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGDC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SGDC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sgdc_pkg.sv -----
// Package of the sorted group distinct count block: item types, tuple layout,
// controller/datapath command and status structs, opcodes and string cleanup.
// No dependencies.
package sgdc_pkg;

   localparam int MAX_TUPLES_DEF = 1024;
   localparam int CNT_W = 11;
   localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_FETCH = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] brand_high;
      logic [15:0] brand_low;
      logic [63:0] type_word0;
      logic [63:0] type_word1;
      logic [63:0] type_word2;
      logic [7:0]  type_tail;
      logic [5:0]  part_size;
      logic [30:0] supplier_key;
   } req_type;

   typedef struct packed {
      logic [63:0] grp_brand_high;
      logic [15:0] grp_brand_low;
      logic [63:0] grp_type_word0;
      logic [63:0] grp_type_word1;
      logic [63:0] grp_type_word2;
      logic [7:0]  grp_type_tail;
      logic [5:0]  grp_size;
      logic [10:0] distinct_count;
      logic        group_present;
      logic        final_group;
      logic        overflowed;
   } rsp_type;

   // Field order makes a plain vector compare equal the sort order.
   typedef struct packed {
      logic [79:0]  brand;
      logic [199:0] ptype;
      logic [5:0]   size;
      logic [30:0]  supplier;
   } tuple_type;

   localparam int TUPLE_W = $bits(tuple_type);
   localparam int KEY_LSB = 31;

   typedef struct packed {
      logic load;
      logic clear;
      logic set_sorted;
      logic sort_init;
      logic sort_start;
      logic sort_step;
      logic sort_tail;
      logic scan_issue;
      logic scan_empty;
      logic scan_first;
      logic scan_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic sorted;
      logic multi;
      logic j_at_lim;
      logic lim_one;
      logic pos_lt;
      logic first_done;
      logic step_done;
      logic rsp_free;
   } sts_type;

   function automatic logic [79:0] clean_brand(input logic [79:0] b);
      logic seen;
      logic [79:0] r;
      seen = 1'b0;
      r = b;
      for (int i = 0; i < 10; i++) begin
         if (seen) begin
            r[79-8*i -: 8] = 8'd0;
         end else if (b[79-8*i -: 8] == 8'd0) begin
            seen = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [199:0] clean_type(input logic [199:0] b);
      logic seen;
      logic [199:0] r;
      seen = 1'b0;
      r = b;
      for (int i = 0; i < 25; i++) begin
         if (seen) begin
            r[199-8*i -: 8] = 8'd0;
         end else if (b[199-8*i -: 8] == 8'd0) begin
            seen = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/sgdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/sgdc_ctrl.sv -----
// Controller of the grouping block: sequences load, bubble sort passes,
// group scan and result hand-off. Depends on sgdc_pkg.
module sgdc_ctrl import sgdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] opcode,
   output logic       req_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);
   typedef enum logic [7:0] {
      S_IDLE       = 8'b00000001,
      S_SORT_START = 8'b00000010,
      S_SORT_RUN   = 8'b00000100,
      S_SORT_TAIL  = 8'b00001000,
      S_SCAN_ISSUE = 8'b00010000,
      S_SCAN_FIRST = 8'b00100000,
      S_SCAN_RUN   = 8'b01000000,
      S_EMIT       = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = (opcode == OP_LOAD);
               cmd.clear = (opcode == OP_CLEAR);
               if (opcode == OP_FETCH) begin
                  if (sts.sorted) begin
                     state_in = S_SCAN_ISSUE;
                  end else if (sts.multi) begin
                     cmd.sort_init = 1'b1;
                     state_in = S_SORT_START;
                  end else begin
                     cmd.set_sorted = 1'b1;
                     state_in = S_SCAN_ISSUE;
                  end
               end
            end
         end
         S_SORT_START: begin
            cmd.sort_start = 1'b1;
            state_in = S_SORT_RUN;
         end
         S_SORT_RUN: begin
            cmd.sort_step = 1'b1;
            if (sts.j_at_lim) begin
               state_in = S_SORT_TAIL;
            end
         end
         S_SORT_TAIL: begin
            cmd.sort_tail = 1'b1;
            if (sts.lim_one) begin
               cmd.set_sorted = 1'b1;
               state_in = S_SCAN_ISSUE;
            end else begin
               state_in = S_SORT_START;
            end
         end
         S_SCAN_ISSUE: begin
            if (sts.pos_lt) begin
               cmd.scan_issue = 1'b1;
               state_in = S_SCAN_FIRST;
            end else begin
               cmd.scan_empty = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_SCAN_FIRST: begin
            cmd.scan_first = 1'b1;
            state_in = sts.first_done ? S_EMIT : S_SCAN_RUN;
         end
         S_SCAN_RUN: begin
            cmd.scan_step = 1'b1;
            if (sts.step_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/sgdc_dp.sv -----
// Datapath of the grouping block: tuple store, counters, sort hold register,
// group scan registers and the result register. Depends on sgdc_pkg, sgdc_ram.
module sgdc_dp import sgdc_pkg::*; #(
   parameter int MAX_TUPLES = MAX_TUPLES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int AW = $clog2(MAX_TUPLES);
   localparam int CW = $clog2(MAX_TUPLES + 1);

   logic [CW-1:0] count_ff, pos_ff, idx_ff;
   logic [AW-1:0] lim_ff, j_ff;
   logic sorted_ff, ovf_ff, present_ff, rsp_valid_ff;
   tuple_type hold_ff, grp_ff, q, ld_tuple, wr_data;
   logic [30:0] prev_ff;
   logic [CNT_W-1:0] cnt_ff;
   rsp_type rsp_ff, rsp_in;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr, j_nx, j_pv;
   logic [CW-1:0] cnt_m1, idx_nx;
   logic full, match, q_less;

   assign full = (count_ff == CW'(MAX_TUPLES));
   assign cnt_m1 = count_ff - CW'(1);
   assign idx_nx = idx_ff + CW'(1);
   assign j_nx = j_ff + AW'(1);
   assign j_pv = j_ff - AW'(1);
   assign match = (q[TUPLE_W-1:KEY_LSB] == grp_ff[TUPLE_W-1:KEY_LSB]);
   assign q_less = (q < hold_ff);

   always_comb begin
      ld_tuple.brand = clean_brand({req_data.brand_high, req_data.brand_low});
      ld_tuple.ptype = clean_type({req_data.type_word0, req_data.type_word1,
                                   req_data.type_word2, req_data.type_tail});
      ld_tuple.size = req_data.part_size;
      ld_tuple.supplier = req_data.supplier_key;
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = ld_tuple;
      rd_addr = j_nx;
      if (cmd.load && !full) begin
         wr_en = 1'b1;
      end else if (cmd.sort_step && (j_ff != '0)) begin
         wr_en = 1'b1;
         wr_addr = j_pv;
         wr_data = q_less ? q : hold_ff;
      end else if (cmd.sort_tail) begin
         wr_en = 1'b1;
         wr_addr = lim_ff;
         wr_data = hold_ff;
      end
      if (cmd.sort_start) begin
         rd_addr = '0;
      end else if (cmd.scan_issue) begin
         rd_addr = pos_ff[AW-1:0];
      end else if (cmd.scan_first) begin
         rd_addr = idx_ff[AW-1:0];
      end else if (cmd.scan_step) begin
         rd_addr = idx_nx[AW-1:0];
      end
   end

   sgdc_ram #(
      .WIDTH(TUPLE_W),
      .DEPTH(MAX_TUPLES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(q)
   );

   always_comb begin
      rsp_in = '0;
      rsp_in.overflowed = ovf_ff;
      if (present_ff) begin
         rsp_in.grp_brand_high = grp_ff.brand[79:16];
         rsp_in.grp_brand_low = grp_ff.brand[15:0];
         rsp_in.grp_type_word0 = grp_ff.ptype[199:136];
         rsp_in.grp_type_word1 = grp_ff.ptype[135:72];
         rsp_in.grp_type_word2 = grp_ff.ptype[71:8];
         rsp_in.grp_type_tail = grp_ff.ptype[7:0];
         rsp_in.grp_size = grp_ff.size;
         rsp_in.distinct_count = cnt_ff;
         rsp_in.group_present = 1'b1;
         rsp_in.final_group = !(pos_ff < count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff <= '0;
         sorted_ff <= 1'b0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
            pos_ff <= '0;
            sorted_ff <= 1'b0;
            ovf_ff <= 1'b0;
         end
         if (cmd.load) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CW'(1);
               sorted_ff <= 1'b0;
               pos_ff <= '0;
            end
         end
         if (cmd.set_sorted) begin
            sorted_ff <= 1'b1;
            pos_ff <= '0;
         end
         if (cmd.scan_first && !(idx_ff < count_ff)) begin
            pos_ff <= idx_ff;
         end
         if (cmd.scan_step && sts.step_done) begin
            pos_ff <= match ? idx_nx : idx_ff;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_init) begin
         lim_ff <= cnt_m1[AW-1:0];
      end
      if (cmd.sort_start) begin
         j_ff <= '0;
      end
      if (cmd.sort_step) begin
         j_ff <= j_nx;
         if ((j_ff == '0) || !q_less) begin
            hold_ff <= q;
         end
      end
      if (cmd.sort_tail) begin
         lim_ff <= lim_ff - AW'(1);
      end
      if (cmd.scan_issue) begin
         idx_ff <= pos_ff + CW'(1);
      end
      if (cmd.scan_empty) begin
         present_ff <= 1'b0;
      end
      if (cmd.scan_first) begin
         grp_ff <= q;
         prev_ff <= q.supplier;
         cnt_ff <= CNT_W'(1);
         present_ff <= 1'b1;
      end
      if (cmd.scan_step && match) begin
         prev_ff <= q.supplier;
         idx_ff <= idx_nx;
         if ((q.supplier != prev_ff) && (cnt_ff != COUNT_MAX)) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      sts.sorted = sorted_ff;
      sts.multi = (count_ff > CW'(1));
      sts.j_at_lim = (j_ff == lim_ff);
      sts.lim_one = (lim_ff == AW'(1));
      sts.pos_lt = (pos_ff < count_ff);
      sts.first_done = !(idx_ff < count_ff);
      sts.step_done = !match || !(idx_nx < count_ff);
      sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// ----- rtl/sorted_group_distinct_count_top.sv -----
// Sorted group distinct count: a load stores one tuple, a clear empties the store.
// A fetch on sorted data scans one group of tuples (one store read each) and returns it.
// The first fetch after loading more than one tuple runs a bubble sort on the single-write,
// single-read store before the scan.
// Synchronous reset empties the store and clears the sorted, overflow and valid flags; no clearing pass.
module sorted_group_distinct_count_top import sgdc_pkg::*; #(
   parameter int MAX_TUPLES = MAX_TUPLES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cmd_type cmd;
   sts_type sts;

   sgdc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .opcode   (req_data.opcode),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   sgdc_dp #(
      .MAX_TUPLES(MAX_TUPLES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );
endmodule

// ----- rtl/sgdc_checker.sv -----
// Port-level checker for the grouping block and its bind to the top level.
// Depends on sgdc_pkg and sorted_group_distinct_count_top_macros.svh.
`include "sorted_group_distinct_count_top_macros.svh"
module sgdc_checker import sgdc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   `SGDC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "Stalled item changed.")
   `SGDC_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && !rsp_data.group_present, (rsp_data.distinct_count == '0) && !rsp_data.final_group, "Empty item carries data.")
   `SGDC_ASSERT_IMP(a_group_count, clock, reset, rsp_valid && rsp_data.group_present, rsp_data.distinct_count != '0, "Group with zero count.")
   `SGDC_ASSERT_IMP(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "Item right after reset.")
endmodule

bind sorted_group_distinct_count_top sgdc_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
